// ----- sv/rvm_pkg.sv -----
// ============================================================================
// rvm_pkg
// Shared types, constants and coefficient tables for the rotation vector to
// rotation matrix pipeline.
// ============================================================================
package rvm_pkg;

    // Pipeline geometry
    localparam int SQRT_CELLS   = 20;
    localparam int DIV_CELLS    = 31;
    localparam int HORNER_CELLS = 5;
    // input, square, sum | sqrt | divide | 4 range steps + q | Horner | 5 tail stages
    localparam int PIPE_DEPTH   = 3 + SQRT_CELLS + DIV_CELLS + 5 + 3 * HORNER_CELLS + 5;

    // Fixed-point constants (Q30 angle and trig values, Q14 matrix entries)
    localparam logic [30:0]        Q30_ONE     = 31'h4000_0000;
    localparam logic [33:0]        Q30_PI      = 34'd3373259426;
    localparam logic [33:0]        Q30_HALF_PI = 34'd1686629713;
    localparam logic [33:0]        Q30_TWO_PI  = 34'd6746518852;
    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam longint unsigned    RECIP_SCALE = 64'd4294967296;

    // Divisors of one Horner step and their truncated 2^32 reciprocals
    typedef struct packed {
        logic [7:0]  k_sin;
        logic [7:0]  k_cos;
        logic [29:0] m_sin;
        logic [29:0] m_cos;
    } horner_coef_t;

    localparam horner_coef_t HORNER_COEF [HORNER_CELLS] = '{
        '{8'd110, 8'd132, 30'(RECIP_SCALE / 110), 30'(RECIP_SCALE / 132)},
        '{8'd72,  8'd90,  30'(RECIP_SCALE / 72),  30'(RECIP_SCALE / 90)},
        '{8'd42,  8'd56,  30'(RECIP_SCALE / 42),  30'(RECIP_SCALE / 56)},
        '{8'd20,  8'd30,  30'(RECIP_SCALE / 20),  30'(RECIP_SCALE / 30)},
        '{8'd6,   8'd12,  30'(RECIP_SCALE / 6),   30'(RECIP_SCALE / 12)}
    };

    // Request: rotation vector, Q3.12 radians
    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
    } rot_in_t;

    // Result: row-major matrix, Q1.14
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } rot_out_t;

    // Square root chain: remainder, partial root, vector riding along
    typedef struct packed {
        logic [39:0]      rem;
        logic [39:0]      res;
        logic [2:0][15:0] vec;
    } sqrt_bus_t;

    // Divider chain: norm, signs, per-lane remainder and quotient
    typedef struct packed {
        logic [19:0]      th;
        logic [2:0]       neg;
        logic [2:0][49:0] rem;
        logic [2:0][30:0] quo;
    } div_bus_t;

    // Trig chain: reduced angle, its square, running Horner terms, axis
    typedef struct packed {
        logic             zero;
        logic             neg_s;
        logic             neg_c;
        logic [30:0]      ang;
        logic [31:0]      q;
        logic [30:0]      t_sin;
        logic [30:0]      t_cos;
        logic [2:0][31:0] u;
    } trig_bus_t;

endpackage

// ----- sv/rvm_sqrt_cell.sv -----
// ============================================================================
// rvm_sqrt_cell
// One bit of the pipelined integer square root: trial subtract at a fixed
// bit pair, shift the partial root, register the result.
// ============================================================================
module rvm_sqrt_cell
    import rvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [4:0] idx,
    input  logic      valid_up,
    input  sqrt_bus_t bus_up,
    output logic      valid_dn,
    output sqrt_bus_t bus_dn
);

    logic      valid_reg;
    sqrt_bus_t bus_reg;
    sqrt_bus_t bus_next;
    logic [39:0] bit_w;
    logic [39:0] trial;

    // Trial subtract of root plus bit
    always_comb
    begin
        bit_w    = 40'd1 << {idx, 1'b0};
        trial    = bus_up.res + bit_w;
        bus_next = bus_up;
        if (bus_up.rem >= trial)
        begin
            bus_next.rem = bus_up.rem - trial;
            bus_next.res = (bus_up.res >> 1) + bit_w;
        end
        else
        begin
            bus_next.res = bus_up.res >> 1;
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_up;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign valid_dn = valid_reg;
    assign bus_dn   = bus_reg;

endmodule

// ----- sv/rvm_div_cell.sv -----
// ============================================================================
// rvm_div_cell
// One quotient bit of the restoring divider, for all three axis lanes at
// once against the shared norm.
// ============================================================================
module rvm_div_cell
    import rvm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] idx,
    input  logic       valid_up,
    input  div_bus_t   bus_up,
    output logic       valid_dn,
    output div_bus_t   bus_dn
);

    logic     valid_reg;
    div_bus_t bus_reg;
    div_bus_t bus_next;
    logic [49:0] dsr;

    // Compare each lane with the shifted norm and subtract on success
    always_comb
    begin
        dsr      = 50'(bus_up.th) << idx;
        bus_next = bus_up;
        for (int l = 0; l < 3; l++)
        begin
            if (bus_up.rem[l] >= dsr)
            begin
                bus_next.rem[l]      = bus_up.rem[l] - dsr;
                bus_next.quo[l][idx] = 1'b1;
            end
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_up;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign valid_dn = valid_reg;
    assign bus_dn   = bus_reg;

endmodule

// ----- sv/rvm_horner_cell.sv -----
// ============================================================================
// rvm_horner_cell
// One Horner step t = 1 - q*t/k for the sine and cosine series, in three
// stages: product, reciprocal multiply, quotient fix-up.
// ============================================================================
module rvm_horner_cell
    import rvm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  horner_coef_t coef,
    input  logic         valid_up,
    input  trig_bus_t    bus_up,
    output logic         valid_dn,
    output trig_bus_t    bus_dn
);

    logic [2:0]  valid_reg;
    trig_bus_t   bus1_reg;
    trig_bus_t   bus2_reg;
    trig_bus_t   bus3_reg;
    trig_bus_t   bus3_next;
    logic [31:0] xs1_reg;
    logic [31:0] xc1_reg;
    logic [31:0] xs2_reg;
    logic [31:0] xc2_reg;
    logic [62:0] prod_s;
    logic [62:0] prod_c;
    logic [31:0] xs1_next;
    logic [31:0] xc1_next;
    logic [61:0] ms_reg;
    logic [61:0] mc_reg;
    logic [61:0] ms_next;
    logic [61:0] mc_next;

    // Exact floor(x / k) from the reciprocal estimate, then 1 - p
    function automatic logic [30:0] finish_step(input logic [31:0] x,
                                                input logic [61:0] m,
                                                input logic [7:0]  k);
        logic [29:0] qq;
        logic [37:0] qk;
        logic [32:0] rem;
        logic [30:0] p;
        qq  = m[61:32];
        qk  = 38'(qq) * 38'(k);
        rem = {1'b0, x} - qk[32:0];
        p   = (rem >= 33'(k)) ? 31'(qq) + 31'd1 : 31'(qq);
        finish_step = (p > Q30_ONE) ? 31'd0 : Q30_ONE - p;
    endfunction

    // Stage 1: q * t, back to Q30
    always_comb
    begin
        prod_s   = 63'(bus_up.q) * 63'(bus_up.t_sin);
        prod_c   = 63'(bus_up.q) * 63'(bus_up.t_cos);
        xs1_next = prod_s[61:30];
        xc1_next = prod_c[61:30];
    end

    // Stage 2: multiply by the reciprocal of k
    always_comb
    begin
        ms_next = 62'(xs1_reg) * 62'(coef.m_sin);
        mc_next = 62'(xc1_reg) * 62'(coef.m_cos);
    end

    // Stage 3: fix up the quotient and form the new terms
    always_comb
    begin
        bus3_next       = bus2_reg;
        bus3_next.t_sin = finish_step(xs2_reg, ms_reg, coef.k_sin);
        bus3_next.t_cos = finish_step(xc2_reg, mc_reg, coef.k_cos);
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 3'b000;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_up};
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        bus1_reg <= bus_up;
        xs1_reg  <= xs1_next;
        xc1_reg  <= xc1_next;
        bus2_reg <= bus1_reg;
        xs2_reg  <= xs1_reg;
        xc2_reg  <= xc1_reg;
        ms_reg   <= ms_next;
        mc_reg   <= mc_next;
        bus3_reg <= bus3_next;
    end

    assign valid_dn = valid_reg[2];
    assign bus_dn   = bus3_reg;

endmodule

// ----- sv/rotation_vector_to_matrix_top.sv -----
// ============================================================================
// rotation_vector_to_matrix_top
// Rodrigues rotation vector (Q3.12) to 3x3 rotation matrix (Q1.14), fully
// pipelined: norm by a square root chain, axis by a divider chain, sine and
// cosine by range reduction and Horner cells, then the matrix products.
// ============================================================================
//
//  channel   | handshake        | payload            | direction
//  ----------+------------------+--------------------+----------
//  request   | start, busy      | request (rot_in_t) | in
//  result    | done (strobe)    | result (rot_out_t) | out
//
//  One request is taken per clock; busy stays low.
//  The pipeline holds the 20-cell square root chain, the 31-cell divider chain
//  and the 5 Horner cells.
//  The result holds for one cycle under done; results keep request order.
//  Reset clears only the valid flags along the pipeline.
//
module rotation_vector_to_matrix_top
    import rvm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rot_in_t  request,
    output logic     done,
    output rot_out_t result
);

    typedef struct packed {
        logic             zero;
        logic             neg_s;
        logic             neg_c;
        logic [33:0]      ang;
        logic [2:0][31:0] u;
    } red_t;

    typedef enum logic [1:0] {
        TERM_DIAG,
        TERM_PLUS,
        TERM_MINUS
    } term_t;

    // Distinct axis products u_a * u_b
    localparam int PAIR_A [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};
    // Per entry: axis product, sine term kind, sine axis
    localparam int    ENTRY_PAIR [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
    localparam term_t ENTRY_TERM [9] = '{TERM_DIAG, TERM_MINUS, TERM_PLUS,
                                         TERM_PLUS, TERM_DIAG, TERM_MINUS,
                                         TERM_MINUS, TERM_PLUS, TERM_DIAG};
    localparam int    ENTRY_AXIS [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};

    // Valid flags of the stages in this module
    logic in_vld_reg, sq_vld_reg, sum_vld_reg;
    logic r1_vld_reg, r2_vld_reg, r3_vld_reg, r4_vld_reg, q_vld_reg;
    logic f1_vld_reg, f2_vld_reg, m1_vld_reg, m2_vld_reg, done_reg;

    // Payload registers
    rot_in_t          in_reg;
    logic [30:0]      sq_reg [3];
    logic [2:0][15:0] vec_sq_reg;
    sqrt_bus_t        root_reg;
    red_t             r1_reg, r2_reg, r3_reg, r4_reg;
    red_t             r1_next, r2_next, r3_next, r4_next;
    trig_bus_t        q_reg, q_next;
    trig_bus_t        f1_reg;
    logic [61:0]      ps_reg;
    logic [62:0]      pc_reg;
    logic signed [31:0] s_reg, c_reg;
    logic signed [32:0] oc_reg;
    logic [2:0][31:0] f2_u_reg;
    logic             f2_zero_reg;
    logic signed [31:0] uu_reg [6];
    logic signed [31:0] us_reg [3];
    logic signed [31:0] m1_c_reg;
    logic signed [32:0] m1_oc_reg;
    logic             m1_zero_reg;
    logic signed [32:0] e0_reg [9];
    logic signed [31:0] m2_us_reg [3];
    logic signed [31:0] m2_c_reg;
    logic             m2_zero_reg;
    rot_out_t         result_reg, result_next;

    // Combinational values
    logic signed [31:0] sq_x, sq_y, sq_z;
    logic [31:0]        sum_next;
    div_bus_t           div_head;
    logic [61:0]        ps_next;
    logic [62:0]        pc_next;
    logic signed [31:0] s_next, c_next;
    logic signed [32:0] oc_next;
    logic signed [31:0] uu_next [6];
    logic signed [31:0] us_next [3];
    logic signed [32:0] e0_next [9];
    logic signed [15:0] ent [9];

    // Chains
    logic      sqrt_vld [SQRT_CELLS + 1];
    sqrt_bus_t sqrt_bus [SQRT_CELLS + 1];
    logic      div_vld  [DIV_CELLS + 1];
    div_bus_t  div_bus  [DIV_CELLS + 1];
    logic      hor_vld  [HORNER_CELLS + 1];
    trig_bus_t hor_bus  [HORNER_CELLS + 1];

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid flags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            r3_vld_reg  <= 1'b0;
            r4_vld_reg  <= 1'b0;
            q_vld_reg   <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            sq_vld_reg  <= in_vld_reg;
            sum_vld_reg <= sq_vld_reg;
            r1_vld_reg  <= div_vld[DIV_CELLS];
            r2_vld_reg  <= r1_vld_reg;
            r3_vld_reg  <= r2_vld_reg;
            r4_vld_reg  <= r3_vld_reg;
            q_vld_reg   <= r4_vld_reg;
            f1_vld_reg  <= hor_vld[HORNER_CELLS];
            f2_vld_reg  <= f1_vld_reg;
            m1_vld_reg  <= f2_vld_reg;
            m2_vld_reg  <= m1_vld_reg;
            done_reg    <= m2_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Squares and their sum
    // ------------------------------------------------------------------
    assign sq_x     = in_reg.rot_x * in_reg.rot_x;
    assign sq_y     = in_reg.rot_y * in_reg.rot_y;
    assign sq_z     = in_reg.rot_z * in_reg.rot_z;
    assign sum_next = 32'(sq_reg[0]) + 32'(sq_reg[1]) + 32'(sq_reg[2]);

    // ------------------------------------------------------------------
    // Square root chain: norm in Q16
    // ------------------------------------------------------------------
    assign sqrt_vld[0] = sum_vld_reg;
    assign sqrt_bus[0] = root_reg;

    for (genvar g = 0; g < SQRT_CELLS; g++)
    begin : g_sqrt
        rvm_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (5'(SQRT_CELLS - 1 - g)),
            .valid_up (sqrt_vld[g]),
            .bus_up   (sqrt_bus[g]),
            .valid_dn (sqrt_vld[g + 1]),
            .bus_dn   (sqrt_bus[g + 1])
        );
    end

    // Load the divider with |v| * 2^34 per lane
    always_comb
    begin
        logic [15:0] mag;
        div_head    = '0;
        div_head.th = sqrt_bus[SQRT_CELLS].res[19:0];
        for (int l = 0; l < 3; l++)
        begin
            mag = sqrt_bus[SQRT_CELLS].vec[l][15] ? 16'(-sqrt_bus[SQRT_CELLS].vec[l])
                                                  : sqrt_bus[SQRT_CELLS].vec[l];
            div_head.neg[l] = sqrt_bus[SQRT_CELLS].vec[l][15];
            div_head.rem[l] = {mag, 34'd0};
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: unit axis in Q30
    // ------------------------------------------------------------------
    assign div_vld[0] = sqrt_vld[SQRT_CELLS];
    assign div_bus[0] = div_head;

    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_div
        rvm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (5'(DIV_CELLS - 1 - g)),
            .valid_up (div_vld[g]),
            .bus_up   (div_bus[g]),
            .valid_dn (div_vld[g + 1]),
            .bus_dn   (div_bus[g + 1])
        );
    end

    // ------------------------------------------------------------------
    // Range reduction of the angle
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [33:0] ang0;
        ang0          = {div_bus[DIV_CELLS].th, 14'd0};
        r1_next.zero  = (div_bus[DIV_CELLS].th == 20'd0);
        r1_next.neg_s = 1'b0;
        r1_next.neg_c = 1'b0;
        r1_next.ang   = (ang0 >= Q30_TWO_PI) ? ang0 - Q30_TWO_PI : ang0;
        for (int l = 0; l < 3; l++)
        begin
            r1_next.u[l] = div_bus[DIV_CELLS].neg[l] ? -32'(div_bus[DIV_CELLS].quo[l])
                                                     : 32'(div_bus[DIV_CELLS].quo[l]);
        end
    end

    // Second wrap by two pi
    always_comb
    begin
        r2_next = r1_reg;
        if (r1_reg.ang >= Q30_TWO_PI)
        begin
            r2_next.ang = r1_reg.ang - Q30_TWO_PI;
        end
    end

    // Fold the lower half turn: both signs flip
    always_comb
    begin
        r3_next = r2_reg;
        if (r2_reg.ang > Q30_PI)
        begin
            r3_next.ang   = r2_reg.ang - Q30_PI;
            r3_next.neg_s = 1'b1;
            r3_next.neg_c = 1'b1;
        end
    end

    // Fold the second quadrant: cosine flips
    always_comb
    begin
        r4_next = r3_reg;
        if (r3_reg.ang > Q30_HALF_PI)
        begin
            r4_next.ang   = Q30_PI - r3_reg.ang;
            r4_next.neg_c = !r3_reg.neg_c;
        end
    end

    // Square of the reduced angle, seed the Horner terms
    always_comb
    begin
        logic [61:0] asq;
        asq           = 62'(r4_reg.ang[30:0]) * 62'(r4_reg.ang[30:0]);
        q_next.zero   = r4_reg.zero;
        q_next.neg_s  = r4_reg.neg_s;
        q_next.neg_c  = r4_reg.neg_c;
        q_next.ang    = r4_reg.ang[30:0];
        q_next.q      = asq[61:30];
        q_next.t_sin  = Q30_ONE;
        q_next.t_cos  = Q30_ONE;
        q_next.u      = r4_reg.u;
    end

    // ------------------------------------------------------------------
    // Horner chain for sine and cosine
    // ------------------------------------------------------------------
    assign hor_vld[0] = q_vld_reg;
    assign hor_bus[0] = q_reg;

    for (genvar g = 0; g < HORNER_CELLS; g++)
    begin : g_horner
        rvm_horner_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .coef     (HORNER_COEF[g]),
            .valid_up (hor_vld[g]),
            .bus_up   (hor_bus[g]),
            .valid_dn (hor_vld[g + 1]),
            .bus_dn   (hor_bus[g + 1])
        );
    end

    // Final series products
    assign ps_next = 62'(hor_bus[HORNER_CELLS].ang) * 62'(hor_bus[HORNER_CELLS].t_sin);
    assign pc_next = 63'(hor_bus[HORNER_CELLS].q) * 63'(hor_bus[HORNER_CELLS].t_cos);

    // Sine and cosine with signs, and one minus cosine
    always_comb
    begin
        logic [31:0] sn;
        logic [32:0] xc;
        logic [31:0] p;
        logic [31:0] cs;
        sn = ps_reg[61:30];
        if (sn > 32'(Q30_ONE))
        begin
            sn = 32'(Q30_ONE);
        end
        xc = pc_reg[62:30];
        p  = xc[32:1];
        cs = (p > 32'(Q30_ONE)) ? 32'd0 : 32'(Q30_ONE) - p;
        s_next  = f1_reg.neg_s ? -$signed(sn) : $signed(sn);
        c_next  = f1_reg.neg_c ? -$signed(cs) : $signed(cs);
        oc_next = $signed({2'b00, Q30_ONE}) - $signed({c_next[31], c_next});
    end

    // Axis products and sine terms
    always_comb
    begin
        logic signed [63:0] pr;
        for (int p = 0; p < 6; p++)
        begin
            pr = $signed(f2_u_reg[PAIR_A[p]]) * $signed(f2_u_reg[PAIR_B[p]]);
            uu_next[p] = pr[61:30];
        end
        for (int k = 0; k < 3; k++)
        begin
            pr = $signed(f2_u_reg[k]) * s_reg;
            us_next[k] = pr[61:30];
        end
    end

    // Scale axis products by one minus cosine
    always_comb
    begin
        logic signed [64:0] pr;
        for (int n = 0; n < 9; n++)
        begin
            pr = uu_reg[ENTRY_PAIR[n]] * m1_oc_reg;
            e0_next[n] = pr[62:30];
        end
    end

    // Add diagonal or sine term, round to Q14 and clamp; a zero norm gives the identity
    always_comb
    begin
        logic signed [33:0] term;
        logic signed [33:0] e;
        logic signed [34:0] rnd;
        logic signed [18:0] sh;
        for (int n = 0; n < 9; n++)
        begin
            case (ENTRY_TERM[n])
                TERM_DIAG:  term = {{2{m2_c_reg[31]}}, m2_c_reg};
                TERM_PLUS:  term = {{2{m2_us_reg[ENTRY_AXIS[n]][31]}},
                                    m2_us_reg[ENTRY_AXIS[n]]};
                TERM_MINUS: term = -{{2{m2_us_reg[ENTRY_AXIS[n]][31]}},
                                     m2_us_reg[ENTRY_AXIS[n]]};
                default:    term = '0;
            endcase
            e   = {e0_reg[n][32], e0_reg[n]} + term;
            rnd = {e[33], e} + 35'sd32768;
            sh  = rnd[34:16];
            if (m2_zero_reg)
            begin
                ent[n] = (ENTRY_TERM[n] == TERM_DIAG) ? Q14_ONE : 16'sd0;
            end
            else if (sh > 19'sd16384)
            begin
                ent[n] = Q14_ONE;
            end
            else if (sh < -19'sd16384)
            begin
                ent[n] = -Q14_ONE;
            end
            else
            begin
                ent[n] = sh[15:0];
            end
        end
        result_next.r00 = ent[0];
        result_next.r01 = ent[1];
        result_next.r02 = ent[2];
        result_next.r10 = ent[3];
        result_next.r11 = ent[4];
        result_next.r12 = ent[5];
        result_next.r20 = ent[6];
        result_next.r21 = ent[7];
        result_next.r22 = ent[8];
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        in_reg       <= request;
        sq_reg[0]    <= sq_x[30:0];
        sq_reg[1]    <= sq_y[30:0];
        sq_reg[2]    <= sq_z[30:0];
        // Lane 0 carries x, lane 2 carries z
        vec_sq_reg   <= {in_reg.rot_z, in_reg.rot_y, in_reg.rot_x};
        root_reg.rem <= {sum_next, 8'd0};
        root_reg.res <= 40'd0;
        root_reg.vec <= vec_sq_reg;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        r3_reg       <= r3_next;
        r4_reg       <= r4_next;
        q_reg        <= q_next;
        f1_reg       <= hor_bus[HORNER_CELLS];
        ps_reg       <= ps_next;
        pc_reg       <= pc_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        oc_reg       <= oc_next;
        f2_u_reg     <= f1_reg.u;
        f2_zero_reg  <= f1_reg.zero;
        uu_reg       <= uu_next;
        us_reg       <= us_next;
        m1_c_reg     <= c_reg;
        m1_oc_reg    <= oc_reg;
        m1_zero_reg  <= f2_zero_reg;
        e0_reg       <= e0_next;
        m2_us_reg    <= us_reg;
        m2_c_reg     <= m1_c_reg;
        m2_zero_reg  <= m1_zero_reg;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every accepted request yields a done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("result missing after pipeline depth");

    // No result without a request at the matching earlier cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without matching request");

    // A zero vector gives the identity matrix
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.rot_x == 16'sd0 && request.rot_y == 16'sd0 &&
         request.rot_z == 16'sd0) |-> ##PIPE_DEPTH
        (result.r00 == Q14_ONE && result.r11 == Q14_ONE && result.r22 == Q14_ONE &&
         result.r01 == 16'sd0 && result.r02 == 16'sd0 && result.r10 == 16'sd0 &&
         result.r12 == 16'sd0 && result.r20 == 16'sd0 && result.r21 == 16'sd0))
        else $error("zero vector did not give identity");
`endif

endmodule

// ----- tb/tb_rotation_vector_to_matrix_top.sv -----
// ============================================================================
// tb_rotation_vector_to_matrix_top
// Drives rotation vectors into the Rodrigues pipeline, predicts each matrix
// with an exact fixed-point model and checks every result in request order.
// ============================================================================
module tb_rotation_vector_to_matrix_top;
    import rvm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1600;
    localparam int N_DIRECT  = 20;
    localparam int CYC_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rot_in_t  request;
    logic     done;
    rot_out_t result;

    rot_out_t matrix_queue[$];
    int       n_errors;
    int       cycle_cnt;
    int       send_idle_pct;

    rotation_vector_to_matrix_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // floor(v / 2^n) for signed values
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned poly_step(longint unsigned q, longint unsigned t,
                                                  longint unsigned k);
        longint unsigned p;
        p = ((q * t) >> 30) / k;
        if (p > 64'd1073741824) return 0;
        return 64'd1073741824 - p;
    endfunction

    function automatic logic signed [15:0] round_q14(longint v);
        longint r;
        r = floor_shr(v + 32768, 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return 16'(r);
    endfunction

    // Compute the rotation matrix of one vector
    function automatic rot_out_t rodrigues_matrix(rot_in_t rq);
        longint v[3];
        longint u[3];
        longint s, c, oc, uu, e, us;
        longint unsigned sq, th, r, q, t, p, sn, cs;
        longint unsigned sk[5];
        longint unsigned ck[5];
        logic [15:0] m[9];
        bit neg_s, neg_c;
        int k;
        rot_out_t o;
        sk = '{110, 72, 42, 20, 6};
        ck = '{132, 90, 56, 30, 12};
        neg_s = 0;
        neg_c = 0;
        v[0] = rq.rot_x;
        v[1] = rq.rot_y;
        v[2] = rq.rot_z;
        sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        if (sq == 0)
        begin
            o = '0;
            o.r00 = Q14_ONE;
            o.r11 = Q14_ONE;
            o.r22 = Q14_ONE;
            return o;
        end
        th = isqrt(sq << 8);
        for (int i = 0; i < 3; i++) u[i] = (v[i] * (64'sd1 << 34)) / longint'(th);
        r = (th << 14) % 64'd6746518852;
        if (r > 64'd3373259426)
        begin
            r -= 64'd3373259426;
            neg_s = 1;
            neg_c = 1;
        end
        if (r > 64'd1686629713)
        begin
            r = 64'd3373259426 - r;
            neg_c = !neg_c;
        end
        q = (r * r) >> 30;
        t = 64'd1073741824;
        for (int i = 0; i < 5; i++) t = poly_step(q, t, sk[i]);
        sn = (r * t) >> 30;
        if (sn > 64'd1073741824) sn = 64'd1073741824;
        t = 64'd1073741824;
        for (int i = 0; i < 5; i++) t = poly_step(q, t, ck[i]);
        p = ((q * t) >> 30) / 2;
        cs = (p > 64'd1073741824) ? 0 : 64'd1073741824 - p;
        s = neg_s ? -longint'(sn) : longint'(sn);
        c = neg_c ? -longint'(cs) : longint'(cs);
        oc = 64'sd1073741824 - c;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                uu = floor_shr(u[i] * u[j], 30);
                e = floor_shr(uu * oc, 30);
                if (i == j)
                    e += c;
                else
                begin
                    k = 3 - i - j;
                    us = floor_shr(u[k] * s, 30);
                    e += (((j - i + 3) % 3) == 2) ? us : -us;
                end
                m[i * 3 + j] = round_q14(e);
            end
        end
        o.r00 = m[0]; o.r01 = m[1]; o.r02 = m[2];
        o.r10 = m[3]; o.r11 = m[4]; o.r12 = m[5];
        o.r20 = m[6]; o.r21 = m[7]; o.r22 = m[8];
        return o;
    endfunction

    function automatic logic [15:0] rand_component();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            3, 4: return 16'($urandom_range(0, 16384)) - 16'd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one request, with a random idle gap in front of it
    task automatic send_vector(rot_in_t rq);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        matrix_queue.push_back(rodrigues_matrix(rq));
        @(negedge clk);
    endtask

    // Compare one matrix entry
    task automatic check_field(string name, logic signed [15:0] want_v,
                               logic signed [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s exp %0d got %0d", name, want_v, got_v);
            n_errors++;
        end
    endtask

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        rot_out_t want;
        if (rst_n && done)
        begin
            if (matrix_queue.size() == 0)
            begin
                $error("result with no request pending");
                n_errors++;
            end
            else
            begin
                want = matrix_queue.pop_front();
                check_field("r00", want.r00, result.r00);
                check_field("r01", want.r01, result.r01);
                check_field("r02", want.r02, result.r02);
                check_field("r10", want.r10, result.r10);
                check_field("r11", want.r11, result.r11);
                check_field("r12", want.r12, result.r12);
                check_field("r20", want.r20, result.r20);
                check_field("r21", want.r21, result.r21);
                check_field("r22", want.r22, result.r22);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYC_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Directed vectors: zero, axis extremes, small angles, mixed signs
    rot_in_t direct_tbl [N_DIRECT] = '{
        '{16'sd0,      16'sd0,      16'sd0},
        '{16'sd1,      16'sd0,      16'sd0},
        '{16'sd0,      -16'sd1,     16'sd0},
        '{16'sd0,      16'sd0,      16'sd1},
        '{16'sd32767,  16'sd0,      16'sd0},
        '{-16'sd32768, 16'sd0,      16'sd0},
        '{16'sd0,      16'sd32767,  16'sd0},
        '{16'sd0,      16'sd0,      -16'sd32768},
        '{16'sd32767,  16'sd32767,  16'sd32767},
        '{-16'sd32768, -16'sd32768, -16'sd32768},
        '{16'sd6434,   16'sd0,      16'sd0},
        '{16'sd12868,  16'sd0,      16'sd0},
        '{16'sd0,      16'sd25736,  16'sd0},
        '{16'sd3715,   16'sd3715,   16'sd3715},
        '{-16'sd4096,  16'sd4096,   -16'sd4096},
        '{16'sd100,    -16'sd200,   16'sd300},
        '{16'sd21845,  -16'sd10923, 16'sd5461},
        '{16'sd6433,   16'sd1,      -16'sd1},
        '{-16'sd1,     -16'sd1,     -16'sd1},
        '{16'sd12867,  16'sd12867,  16'sd0}
    };

    initial
    begin
        rot_in_t rq;
        rot_out_t ident;
        int drain;
        n_errors      = 0;
        cycle_cnt     = 0;
        send_idle_pct = 0;
        start         = 1'b0;
        request       = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; the zero vector must give the identity exactly
        ident = '0;
        ident.r00 = 16'sd16384;
        ident.r11 = 16'sd16384;
        ident.r22 = 16'sd16384;
        if (rodrigues_matrix(direct_tbl[0]) !== ident)
        begin
            $error("identity exp %h got %h", ident, rodrigues_matrix(direct_tbl[0]));
            n_errors++;
        end
        for (int i = 0; i < N_DIRECT; i++)
            send_vector(direct_tbl[i]);

        // Random phases: sender idles, then more, then not at all
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 49 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++)
            begin
                rq.rot_x = rand_component();
                rq.rot_y = rand_component();
                rq.rot_z = rand_component();
                send_vector(rq);
            end
        end
        start <= 1'b0;

        // Drain the pipeline
        drain = 0;
        while (matrix_queue.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (matrix_queue.size() != 0)
        begin
            $error("%0d results missing", matrix_queue.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rvm_pkg.sv
sv/rvm_sqrt_cell.sv
sv/rvm_div_cell.sv
sv/rvm_horner_cell.sv
sv/rotation_vector_to_matrix_top.sv
tb/tb_rotation_vector_to_matrix_top.sv
